// ----- hw/rtl/mscd_pkg.sv -----
// Shared types, constants and helpers for the stick cutting cost engine.
package mscd_pkg;

  localparam int COST_W = 16;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_IVL,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic en;
    logic diag_a;
    logic diag_b;
  } cost_rd_t;

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  function automatic logic [COST_W-1:0] min_cost(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
    return (b < a) ? b : a;
  endfunction

endpackage

// ----- hw/rtl/mscd_pos_store.sv -----
// Cut position memory with two registered read ports and piece length output.
module mscd_pos_store #(
  parameter int MAX_SEGMENTS  = 64,
  parameter int POSITION_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]      wr_addr,
  input  logic [POSITION_BITS-1:0]             wr_data,
  input  logic                                 rd_en,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]      rd_lo,
  input  logic [$clog2(MAX_SEGMENTS)-1:0]      rd_hi,
  output logic [mscd_pkg::COST_W-1:0]          piece_len
);

  localparam int IW = $clog2(MAX_SEGMENTS);

  logic [POSITION_BITS-1:0] mem [MAX_SEGMENTS];
  logic [POSITION_BITS-1:0] left_r;
  logic [POSITION_BITS-1:0] right_r;
  logic                     left_zero_r;
  logic [POSITION_BITS-1:0] left_val;
  logic [POSITION_BITS-1:0] diff;
  logic [32:0]              diff_ext;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      left_r      <= mem[rd_lo - IW'(1)];
      right_r     <= mem[rd_hi];
      left_zero_r <= (rd_lo == '0);
    end
  end

  always_comb begin
    left_val  = left_zero_r ? '0 : left_r;
    diff      = (right_r >= left_val) ? (right_r - left_val) : '0;
    diff_ext  = 33'(diff);
    piece_len = (diff_ext > 33'(mscd_pkg::COST_MAX)) ? mscd_pkg::COST_MAX
                                                     : diff_ext[mscd_pkg::COST_W-1:0];
  end

endmodule

// ----- hw/rtl/mscd_cost_unit.sv -----
// Interval cost table memory with two registered reads and the split cost adder.
module mscd_cost_unit #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mscd_pkg::cost_rd_t                   rd,
  input  logic [2*$clog2(MAX_SEGMENTS)-1:0]    rd_addr_a,
  input  logic [2*$clog2(MAX_SEGMENTS)-1:0]    rd_addr_b,
  input  logic                                 wr_en,
  input  logic [2*$clog2(MAX_SEGMENTS)-1:0]    wr_addr,
  input  logic [mscd_pkg::COST_W-1:0]          wr_data,
  output logic                                 pair_vld,
  output logic [mscd_pkg::COST_W-1:0]          pair_cost
);

  localparam int AW    = 2 * $clog2(MAX_SEGMENTS);
  localparam int DEPTH = 1 << AW;

  logic [mscd_pkg::COST_W-1:0] mem [DEPTH];
  logic [mscd_pkg::COST_W-1:0] a_r;
  logic [mscd_pkg::COST_W-1:0] b_r;
  logic                        diag_a_r;
  logic                        diag_b_r;
  logic                        vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd.en) begin
      a_r      <= mem[rd_addr_a];
      b_r      <= mem[rd_addr_b];
      diag_a_r <= rd.diag_a;
      diag_b_r <= rd.diag_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= rd.en;
    end
  end

  // single-segment pieces cost nothing and are never stored
  assign pair_vld  = vld_r;
  assign pair_cost = mscd_pkg::sat_add(diag_a_r ? '0 : a_r, diag_b_r ? '0 : b_r);

endmodule

// ----- hw/rtl/min_cost_stick_cutting_dp.sv -----
// Minimum-cost stick cutting engine: loads cut positions, then solves the interval DP.
// Each cut item is stored in the position memory while fewer than MAX_SEGMENTS - 1 cuts are
// held; a cut beyond that marks the case overflowed. The length item starts the solve over
// n = cuts + 1 segments: every interval (lo, hi) is handled as a position fetch, one split
// per cycle through the two read ports of the cost table, then write-back; no input is
// taken meanwhile. Overflowed cases and cases with no cuts skip the solve and go straight
// from the length item to posting their result. The result sits in an output register, so
// cut items keep flowing while it waits to be taken.
module min_cost_stick_cutting_dp #(
  parameter int MAX_SEGMENTS  = 64,
  parameter int POSITION_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [POSITION_BITS-1:0]    in_position,
  input  logic                        in_is_length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_min_cost,
  output logic                        out_overflow
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CW-1:0] CUT_LIMIT = CW'(MAX_SEGMENTS - 1);

  mscd_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]               count_r, count_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [CW-1:0]               n_r, n_nxt;
  logic [IW-1:0]               span_r, span_nxt;
  logic [IW-1:0]               lo_r, lo_nxt;
  logic [IW-1:0]               k_r, k_nxt;
  logic [mscd_pkg::COST_W-1:0] best_r, best_nxt;
  logic [mscd_pkg::COST_W-1:0] res_cost_r, res_cost_nxt;
  logic                        res_ovf_r, res_ovf_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [mscd_pkg::COST_W-1:0] out_cost_r, out_cost_nxt;
  logic                        out_ovf_r, out_ovf_nxt;

  logic [IW-1:0]               hi;
  logic [IW-1:0]               k_p1;
  logic                        in_acc;
  logic                        pos_wr_en;
  logic [IW-1:0]               pos_wr_addr;
  logic                        pos_rd_en;
  logic [mscd_pkg::COST_W-1:0] piece_len;
  mscd_pkg::cost_rd_t          cost_rd;
  logic                        cost_wr_en;
  logic [mscd_pkg::COST_W-1:0] final_cost;
  logic                        pair_vld;
  logic [mscd_pkg::COST_W-1:0] pair_cost;

  assign hi       = lo_r + span_r;
  assign k_p1     = k_r + IW'(1);
  assign in_ready = (state_r == mscd_pkg::S_LOAD);
  assign in_acc   = in_valid && in_ready;

  assign final_cost = mscd_pkg::sat_add(piece_len, mscd_pkg::min_cost(best_r, pair_cost));

  mscd_pos_store #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .POSITION_BITS(POSITION_BITS)
  ) u_pos (
    .clk      (clk),
    .wr_en    (pos_wr_en),
    .wr_addr  (pos_wr_addr),
    .wr_data  (in_position),
    .rd_en    (pos_rd_en),
    .rd_lo    (lo_r),
    .rd_hi    (hi),
    .piece_len(piece_len)
  );

  mscd_cost_unit #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_cost (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd       (cost_rd),
    .rd_addr_a({lo_r, k_r}),
    .rd_addr_b({k_p1, hi}),
    .wr_en    (cost_wr_en),
    .wr_addr  ({lo_r, hi}),
    .wr_data  (final_cost),
    .pair_vld (pair_vld),
    .pair_cost(pair_cost)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    span_nxt      = span_r;
    lo_nxt        = lo_r;
    k_nxt         = k_r;
    best_nxt      = best_r;
    res_cost_nxt  = res_cost_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cost_nxt  = out_cost_r;
    out_ovf_nxt   = out_ovf_r;
    pos_wr_en     = 1'b0;
    pos_wr_addr   = count_r[IW-1:0];
    pos_rd_en     = 1'b0;
    cost_rd       = '0;
    cost_wr_en    = 1'b0;

    unique case (state_r)
      mscd_pkg::S_LOAD: begin
        if (in_acc && !in_is_length) begin
          if (count_r < CUT_LIMIT) begin
            pos_wr_en = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end else if (in_acc) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          if (ovf_r) begin
            res_cost_nxt = '0;
            res_ovf_nxt  = 1'b1;
            state_nxt    = mscd_pkg::S_DONE;
          end else begin
            pos_wr_en   = 1'b1;
            n_nxt       = count_r + CW'(1);
            res_ovf_nxt = 1'b0;
            if (count_r == '0) begin
              res_cost_nxt = '0;
              state_nxt    = mscd_pkg::S_DONE;
            end else begin
              span_nxt  = IW'(1);
              lo_nxt    = '0;
              state_nxt = mscd_pkg::S_IVL;
            end
          end
        end
      end
      mscd_pkg::S_IVL: begin
        pos_rd_en = 1'b1;
        k_nxt     = lo_r;
        best_nxt  = mscd_pkg::COST_MAX;
        state_nxt = mscd_pkg::S_SCAN;
      end
      mscd_pkg::S_SCAN: begin
        cost_rd.en     = 1'b1;
        cost_rd.diag_a = (k_r == lo_r);
        cost_rd.diag_b = (k_p1 == hi);
        k_nxt          = k_p1;
        if (pair_vld) begin
          best_nxt = mscd_pkg::min_cost(best_r, pair_cost);
        end
        if (k_p1 == hi) begin
          state_nxt = mscd_pkg::S_DRAIN;
        end
      end
      mscd_pkg::S_DRAIN: begin
        cost_wr_en = 1'b1;
        if (CW'(hi) + CW'(1) < n_r) begin
          lo_nxt    = lo_r + IW'(1);
          state_nxt = mscd_pkg::S_IVL;
        end else if (CW'(span_r) + CW'(1) < n_r) begin
          span_nxt  = span_r + IW'(1);
          lo_nxt    = '0;
          state_nxt = mscd_pkg::S_IVL;
        end else begin
          res_cost_nxt = final_cost;
          state_nxt    = mscd_pkg::S_DONE;
        end
      end
      mscd_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cost_nxt  = res_cost_r;
          out_ovf_nxt   = res_ovf_r;
          state_nxt     = mscd_pkg::S_LOAD;
        end
      end
      default: begin
        state_nxt = mscd_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mscd_pkg::S_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    span_r     <= span_nxt;
    lo_r       <= lo_nxt;
    k_r        <= k_nxt;
    best_r     <= best_nxt;
    res_cost_r <= res_cost_nxt;
    res_ovf_r  <= res_ovf_nxt;
    out_cost_r <= out_cost_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_min_cost = out_cost_r;
  assign out_overflow = out_ovf_r;

endmodule

// ----- hw/rtl/mscd_checker.sv -----
// Port-level checks for the stick cutting engine, bound to the top level.
module mscd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_is_length,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_min_cost,
  input logic        out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_cost) && $stable(out_overflow))
    else $error("result item changed or dropped while stalled");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_min_cost == 16'd0)
    else $error("overflow result carries nonzero cost");

  a_len_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_length |=> !in_ready)
    else $error("input taken right after a length item");

  a_cut_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_is_length |=> in_ready)
    else $error("cut item stalled the input");

endmodule

bind min_cost_stick_cutting_dp mscd_checker u_mscd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_is_length(in_is_length),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_min_cost(out_min_cost),
  .out_overflow(out_overflow)
);

// ----- test/tb_min_cost_stick_cutting_dp.sv -----
// Self-checking testbench for the stick cutting cost engine: random cases, stalls, DP predictor.
module tb_min_cost_stick_cutting_dp;

  localparam int MAX_SEG    = 64;
  localparam int POS_W      = 10;
  localparam int COST_W     = mscd_pkg::COST_W;
  localparam int N_RANDOM   = 850;
  localparam int QUIET_LIMIT = 250000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             is_length;
  } stick_item_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic              overflow;
  } cut_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [POS_W-1:0]  in_position = '0;
  logic              in_is_length = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [COST_W-1:0] out_min_cost;
  logic              out_overflow;

  min_cost_stick_cutting_dp #(
    .MAX_SEGMENTS (MAX_SEG),
    .POSITION_BITS(POS_W)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_position (in_position),
    .in_is_length(in_is_length),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_min_cost(out_min_cost),
    .out_overflow(out_overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  stick_item_t stick_items[$];
  cut_result_t expected_costs[$];
  stick_item_t next_item;
  int          total_items = 0;
  int          items_accepted = 0;
  int          results_seen = 0;
  int          err_count = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;

  // predictor state
  logic [POS_W-1:0]  cut_mem [MAX_SEG];
  int unsigned       cut_count = 0;
  bit                cut_ovf = 1'b0;
  logic [COST_W-1:0] span_cost [MAX_SEG][MAX_SEG];

  function automatic logic [COST_W-1:0] clip_add(input int unsigned a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > 65535) ? 16'hFFFF : s[COST_W-1:0];
  endfunction

  task automatic predict_item(input logic [POS_W-1:0] pos, input logic is_len);
    cut_result_t r;
    int unsigned n, span, lo, hi, k, best, c, left, right, plen;
    if (!is_len) begin
      if (cut_count < MAX_SEG - 1) begin
        cut_mem[cut_count] = pos;
        cut_count++;
      end else begin
        cut_ovf = 1'b1;
      end
    end else begin
      if (cut_ovf) begin
        r.min_cost = '0;
        r.overflow = 1'b1;
      end else begin
        cut_mem[cut_count] = pos;
        n = cut_count + 1;
        for (lo = 0; lo < n; lo++) span_cost[lo][lo] = '0;
        for (span = 1; span < n; span++) begin
          for (lo = 0; lo + span < n; lo++) begin
            hi = lo + span;
            best = 65535;
            for (k = lo; k < hi; k++) begin
              c = clip_add(span_cost[lo][k], span_cost[k+1][hi]);
              if (c < best) best = c;
            end
            left  = (lo > 0) ? cut_mem[lo-1] : 0;
            right = cut_mem[hi];
            plen  = (right >= left) ? right - left : 0;
            span_cost[lo][hi] = clip_add(plen, best);
          end
        end
        r.min_cost = span_cost[0][n-1];
        r.overflow = 1'b0;
      end
      expected_costs.push_back(r);
      cut_count = 0;
      cut_ovf = 1'b0;
    end
  endtask

  task automatic push_item(input int unsigned pos, input bit is_len);
    stick_item_t it;
    it.position  = pos[POS_W-1:0];
    it.is_length = is_len;
    stick_items.push_back(it);
  endtask

  // ncuts cuts, monotonic when ordered, then the length item
  task automatic add_case(input int ncuts, input bit ordered);
    int unsigned p, gap;
    int i;
    p = 0;
    gap = (2 * 1023) / (ncuts + 1);
    for (i = 0; i < ncuts; i++) begin
      if (ordered) begin
        p = p + $urandom_range(0, gap);
        if (p > 1023) p = 1023;
      end else begin
        p = $urandom_range(0, 1023);
      end
      push_item(p, 1'b0);
    end
    if (ordered && $urandom_range(0, 9) < 8) push_item($urandom_range(p, 1023), 1'b1);
    else push_item($urandom_range(0, 1023), 1'b1);
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    err_count++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(in_position, in_is_length);
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (stick_items.size() > 0 &&
            ((items_accepted >= 300 && items_accepted < 450) || $urandom_range(0, 99) >= 38)) begin
          next_item = stick_items.pop_front();
          in_valid     <= 1'b1;
          in_position  <= next_item.position;
          in_is_length <= next_item.is_length;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen == 20) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (results_seen >= 40 && results_seen < 60) || $urandom_range(0, 99) >= 38;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_costs.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        if (out_min_cost !== expected_costs[0].min_cost)
          report_mismatch($sformatf("min_cost %0d, expected %0d", out_min_cost,
                                    expected_costs[0].min_cost));
        if (out_overflow !== expected_costs[0].overflow)
          report_mismatch($sformatf("overflow %0b, expected %0b", out_overflow,
                                    expected_costs[0].overflow));
        void'(expected_costs.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int r;
    // directed cases
    push_item(500, 1'b1);
    push_item(0, 1'b1);
    push_item(0, 1'b0); push_item(1023, 1'b0); push_item(1023, 1'b1);
    push_item(2, 1'b0); push_item(4, 1'b0); push_item(7, 1'b0); push_item(10, 1'b1);
    push_item(900, 1'b0); push_item(100, 1'b0); push_item(500, 1'b0); push_item(300, 1'b1);
    push_item(512, 1'b0); push_item(0, 1'b1);
    push_item(1, 1'b0); push_item(3, 1'b0); push_item(4, 1'b0); push_item(5, 1'b0);
    push_item(7, 1'b1);
    // full store, then one cut too many
    add_case(MAX_SEG - 1, 1'b1);
    add_case(MAX_SEG, 1'b1);
    while (stick_items.size() < N_RANDOM) begin
      r = $urandom_range(0, 99);
      if (r < 5)       add_case($urandom_range(50, MAX_SEG - 1), $urandom_range(0, 3) != 0);
      else if (r < 9)  add_case($urandom_range(MAX_SEG, MAX_SEG + 6), $urandom_range(0, 1));
      else if (r < 15) add_case(0, 1'b1);
      else             add_case($urandom_range(1, 12), $urandom_range(0, 4) != 0);
    end
    total_items = stick_items.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted < total_items || expected_costs.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0 && expected_costs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
